>>> rtl/jsu_pkg.sv
// jsu_pkg: shared types and constants for the json string unescaper
// result item layout and result kind codes; no dependencies
package jsu_pkg;

    // most result items one input item can cause
    localparam int MAX_RES = 7;

    // result kind codes
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } res_t;

    typedef res_t [MAX_RES-1:0] res_list_t;

endpackage

>>> rtl/jsu_decode.sv
// jsu_decode: parser state machine and utf-8 encoder of the string unescaper
// depends on jsu_pkg; builds the full result list of one item combinationally
module jsu_decode import jsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       start_req,
    input  logic [7:0] in_byte,
    input  logic       end_of_line,
    output res_list_t  res_list,
    output logic [2:0] res_cnt
);

    typedef enum logic [3:0] {
        M_IDLE     = 4'd0,
        M_TEXT     = 4'd1,
        M_ESC      = 4'd2,
        M_HEX1     = 4'd3,
        M_HIGH     = 4'd4,
        M_HIGH_ESC = 4'd5,
        M_HEX2     = 4'd6,
        M_DONE     = 4'd7,
        M_ERROR    = 4'd8
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [2:0] n;
        res_t [3:0] q;
    } act_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] pend_reg, pend_next;

    function automatic res_t dbyte(input logic [7:0] b);
        res_t r;
        r.kind = KIND_DATA;
        r.data = b;
        return r;
    endfunction

    function automatic res_t flag(input logic [1:0] k);
        res_t r;
        r.kind = k;
        r.data = 8'h00;
        return r;
    endfunction

    function automatic act_t enc(input logic [20:0] cp);
        act_t a;
        a      = '0;
        a.mode = M_TEXT;
        if (cp <= 21'h00007F) begin
            a.n    = 3'd1;
            a.q[0] = dbyte(cp[7:0]);
        end else if (cp <= 21'h0007FF) begin
            a.n    = 3'd2;
            a.q[0] = dbyte({3'b110, cp[10:6]});
            a.q[1] = dbyte({2'b10, cp[5:0]});
        end else if (cp <= 21'h00FFFF) begin
            a.n    = 3'd3;
            a.q[0] = dbyte({4'b1110, cp[15:12]});
            a.q[1] = dbyte({2'b10, cp[11:6]});
            a.q[2] = dbyte({2'b10, cp[5:0]});
        end else begin
            a.n    = 3'd4;
            a.q[0] = dbyte({5'b11110, cp[20:18]});
            a.q[1] = dbyte({2'b10, cp[17:12]});
            a.q[2] = dbyte({2'b10, cp[11:6]});
            a.q[3] = dbyte({2'b10, cp[5:0]});
        end
        return a;
    endfunction

    function automatic act_t text_fn(input logic [7:0] c);
        act_t a;
        a      = '0;
        a.mode = M_TEXT;
        if (c == 8'h5C) begin
            a.mode = M_ESC;
        end else if (c == 8'h22) begin
            a.mode = M_DONE;
            a.n    = 3'd1;
            a.q[0] = flag(KIND_DONE);
        end else begin
            a.n    = 3'd1;
            a.q[0] = dbyte(c);
        end
        return a;
    endfunction

    // 'u' leaves mode HEX1; caller clears the digit accumulator
    function automatic act_t esc_fn(input logic [7:0] c);
        act_t a;
        a      = '0;
        a.mode = M_TEXT;
        a.n    = 3'd1;
        case (c)
            8'h22: a.q[0] = dbyte(8'h22);
            8'h5C: a.q[0] = dbyte(8'h5C);
            8'h2F: a.q[0] = dbyte(8'h2F);
            8'h6E: a.q[0] = dbyte(8'h0A);
            8'h72: a.q[0] = dbyte(8'h0D);
            8'h74: a.q[0] = dbyte(8'h09);
            8'h62: a.q[0] = dbyte(8'h08);
            8'h66: a.q[0] = dbyte(8'h0C);
            8'h75: begin
                a.mode = M_HEX1;
                a.n    = 3'd0;
            end
            default: begin
                a.mode = M_ERROR;
                a.q[0] = flag(KIND_ERROR);
            end
        endcase
        return a;
    endfunction

    // high surrogate waits (caller latches it), low surrogate alone is replaced
    function automatic act_t first_fn(input logic [15:0] cp);
        act_t a;
        if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
            a      = '0;
            a.mode = M_HIGH;
        end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
            a = enc(21'h00FFFD);
        end else begin
            a = enc({5'd0, cp});
        end
        return a;
    endfunction

    always_comb begin
        mode_t       m;
        logic [15:0] acc;
        logic [2:0]  cnt;
        logic [15:0] pend;
        logic        hv;
        logic [3:0]  hd;
        logic [15:0] acc_sh;
        logic [2:0]  cnt_inc;
        logic [20:0] pair_cp;
        logic        pre;
        logic        eol_err;
        act_t        a;
        logic [2:0]  off;
        logic [2:0]  j;

        m    = start_req ? M_TEXT : mode_reg;
        acc  = start_req ? 16'h0000 : acc_reg;
        cnt  = start_req ? 3'd0 : cnt_reg;
        pend = start_req ? 16'h0000 : pend_reg;

        hv = 1'b1;
        hd = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hd = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            hd = in_byte[3:0] + 4'd9;
        end else begin
            hv = 1'b0;
        end
        acc_sh  = {acc[11:0], hd};
        cnt_inc = cnt + 3'd1;
        pair_cp = {1'b0, pend[9:0], acc_sh[9:0]} + 21'h010000;

        acc_next  = acc;
        cnt_next  = cnt;
        pend_next = pend;
        pre       = 1'b0;
        eol_err   = 1'b0;
        a         = '0;
        a.mode    = m;

        case (m)
            M_TEXT: a = text_fn(in_byte);
            M_ESC:  a = esc_fn(in_byte);
            M_HEX1: begin
                if (!hv) begin
                    a.mode = M_ERROR;
                    a.n    = 3'd1;
                    a.q[0] = flag(KIND_ERROR);
                end else begin
                    acc_next = acc_sh;
                    cnt_next = cnt_inc;
                    if (cnt_inc[2]) begin
                        a = first_fn(acc_sh);
                    end
                end
            end
            M_HIGH: begin
                if (in_byte == 8'h5C) begin
                    a.mode = M_HIGH_ESC;
                end else begin
                    pre = 1'b1;
                    a   = text_fn(in_byte);
                end
            end
            M_HIGH_ESC: begin
                if (in_byte == 8'h75) begin
                    a.mode = M_HEX2;
                end else begin
                    pre = 1'b1;
                    a   = esc_fn(in_byte);
                end
            end
            M_HEX2: begin
                if (!hv) begin
                    pre    = 1'b1;
                    a.mode = M_ERROR;
                    a.n    = 3'd1;
                    a.q[0] = flag(KIND_ERROR);
                end else begin
                    acc_next = acc_sh;
                    cnt_next = cnt_inc;
                    if (cnt_inc[2]) begin
                        if (acc_sh >= 16'hDC00 && acc_sh <= 16'hDFFF) begin
                            a = enc(pair_cp);
                        end else begin
                            pre = 1'b1;
                            a   = first_fn(acc_sh);
                        end
                    end
                end
            end
            default: ;
        endcase

        // entering a hex escape restarts the digit gathering
        if ((a.mode == M_HEX1 || a.mode == M_HEX2) && m != a.mode) begin
            acc_next = 16'h0000;
            cnt_next = 3'd0;
        end
        if (a.mode == M_HIGH && m != M_HIGH) begin
            pend_next = acc_sh;
        end

        mode_next = a.mode;
        if (end_of_line && mode_next != M_IDLE && mode_next != M_DONE &&
            mode_next != M_ERROR) begin
            eol_err   = 1'b1;
            mode_next = M_ERROR;
        end

        // result list: optional replacement char, main part, optional error
        off     = pre ? 3'd3 : 3'd0;
        res_cnt = off + a.n + {2'b00, eol_err};
        for (int i = 0; i < MAX_RES; i++) begin
            j = 3'(i) - off;
            if (3'(i) < off) begin
                res_list[i] = dbyte((i == 0) ? 8'hEF : ((i == 1) ? 8'hBF : 8'hBD));
            end else if (j < a.n) begin
                res_list[i] = a.q[j[1:0]];
            end else begin
                res_list[i] = flag(KIND_ERROR);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            acc_reg  <= 16'h0000;
            cnt_reg  <= 3'd0;
            pend_reg <= 16'h0000;
        end else if (step) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
        end
    end

endmodule

>>> rtl/jsu_res_buf.sv
// jsu_res_buf: result register that holds the results of one item and
// hands them out one per cycle while m_tready is high; depends on jsu_pkg
module jsu_res_buf import jsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  res_list_t  res_list,
    input  logic [2:0] res_cnt,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // kind
    output logic       m_tlast    // last
);

    res_list_t  q_reg;
    logic [2:0] rem_reg;
    logic       pop;

    assign pop      = (rem_reg != 3'd0) && m_tready;
    assign free     = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && m_tready);
    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tdata  = q_reg[0].data;
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = (rem_reg == 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 3'd0;
        end else if (load) begin
            rem_reg <= res_cnt;
        end else if (pop) begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= res_list;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

endmodule

>>> rtl/json_string_unescape_utf8.sv
// Streaming JSON string unescaper. Feed it the bytes of a string value, one
// item per byte, starting with the byte after the opening quote (s_tuser set
// on that item). It returns the unescaped text as UTF-8, one byte per result
// item, followed by a done item at the closing quote or an error item on a
// malformed escape or a line that ends inside the string; after either it
// ignores bytes until the next start. Timing: an item is taken into an input
// register, decoded combinationally into the result register, and its results
// leave one per cycle while m_tready is high. Items that give zero or one
// result flow at one item per cycle while m_tready is high; an item that
// gives n results (up to 7 for a broken surrogate pair with end of line)
// occupies the result register until all n have left, and the next item
// waits in the input register until then, stalling the input.
// depends on jsu_pkg, jsu_decode and jsu_res_buf
module json_string_unescape_utf8 import jsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // input bytes
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tuser,   // start_req
    input  logic       s_tlast,   // end_of_line
    // result items
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte (zero unless kind is data)
    output logic [1:0] m_tuser,   // kind: 0 data, 1 done, 2 error
    output logic       m_tlast    // last result of its input item
);

    // input register
    logic       in_vld_reg;
    logic       start_reg;
    logic [7:0] byte_reg;
    logic       eol_reg;

    logic       buf_free;
    logic       step;
    res_list_t  res_list;
    logic [2:0] res_cnt;

    // the held item moves into the result register once that one empties
    assign step     = in_vld_reg && buf_free;
    assign s_tready = !in_vld_reg || buf_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (step) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            start_reg <= s_tuser;
            byte_reg  <= s_tdata;
            eol_reg   <= s_tlast;
        end
    end

    // parser state and the result list of the held item
    jsu_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .start_req   (start_reg),
        .in_byte     (byte_reg),
        .end_of_line (eol_reg),
        .res_list    (res_list),
        .res_cnt     (res_cnt)
    );

    // result register, drained one item per cycle while m_tready is high
    jsu_res_buf u_res_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .res_list (res_list),
        .res_cnt  (res_cnt),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
